[src/brtl_pkg.sv]
// Package for the bounded ratio test limit block: widths, payload structs,
// register indexes, divider state type. No dependencies.
`timescale 1ns / 1ps
package brtl_pkg;

  localparam int DATA_WIDTH = 64;
  localparam int REG_WIDTH  = 33;
  localparam int NUM_WIDTH  = DATA_WIDTH + 2;
  localparam int DIVD_W     = NUM_WIDTH + 32;
  localparam int DIV_STEPS  = DATA_WIDTH + 32 + 2;
  localparam int CNT_WIDTH  = $clog2(DIV_STEPS + 1);

  typedef enum logic [0:0] {
    REG_ZERO_TOL    = 1'b0,
    REG_BOUND_SHIFT = 1'b1
  } reg_idx_t;

  localparam logic [REG_WIDTH-1:0] TOL_RESET   = REG_WIDTH'(4295);
  localparam logic [REG_WIDTH-1:0] SHIFT_RESET = REG_WIDTH'(4295);

  typedef struct packed {
    logic signed [63:0] update_value;
    logic signed [63:0] current_value;
    logic signed [63:0] lower_bound;
    logic signed [63:0] upper_bound;
    logic               lower_finite;
    logic               upper_finite;
    logic signed [63:0] start_limit;
    logic               first_element;
    logic               last_element;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] step_limit;
    logic               limit_moved;
  } out_item_t;

  // Classified job passed from front to back.
  typedef struct packed {
    logic                        active;
    logic                        fin;
    logic                        first;
    logic                        last;
    logic [DATA_WIDTH-1:0]       start;
    logic signed [NUM_WIDTH-1:0] num;
    logic [DATA_WIDTH-1:0]       den;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_APPLY,
    ST_OUT
  } back_state_t;

endpackage

[src/brtl_front.sv]
// Front part: registers, zero test, bound selection and numerator build.
// Depends on brtl_pkg. Keeps its own copy of the search mode.
`timescale 1ns / 1ps
module brtl_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  brtl_pkg::in_item_t  in_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  output logic                job_valid,
  input  logic                job_ready,
  output brtl_pkg::job_t      job
);
  import brtl_pkg::*;

  logic [REG_WIDTH-1:0] tol_r, shift_r;
  logic                 upward_r;
  logic                 mode;
  logic [DATA_WIDTH-1:0] x, cur, bnd, st;
  logic signed [DATA_WIDTH:0] tol_s;
  logic pos, neg, use_up;
  logic signed [NUM_WIDTH-1:0] num;

  assign cfg_ready = 1'b1;
  assign in_ready  = job_ready;
  assign job_valid = in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r    <= TOL_RESET;
      shift_r  <= SHIFT_RESET;
      upward_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (reg_idx_t'(cfg_index))
          REG_ZERO_TOL:    tol_r   <= cfg_data[REG_WIDTH-1:0];
          REG_BOUND_SHIFT: shift_r <= cfg_data[REG_WIDTH-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready && in_data.first_element) upward_r <= st[DATA_WIDTH-1];
    end
  end

  always_comb begin
    x   = in_data.update_value[DATA_WIDTH-1:0];
    cur = in_data.current_value[DATA_WIDTH-1:0];
    st  = in_data.start_limit[DATA_WIDTH-1:0];
    mode = in_data.first_element ? st[DATA_WIDTH-1] : upward_r;
    tol_s = (DATA_WIDTH+1)'(tol_r);
    pos = $signed({x[DATA_WIDTH-1], x}) > tol_s;
    neg = $signed({x[DATA_WIDTH-1], x}) < -tol_s;
    use_up = mode ? neg : pos;
    bnd = use_up ? in_data.upper_bound[DATA_WIDTH-1:0] : in_data.lower_bound[DATA_WIDTH-1:0];
    num = NUM_WIDTH'($signed(bnd)) - NUM_WIDTH'($signed(cur));
    num = use_up ? num + $signed(NUM_WIDTH'(shift_r)) : num - $signed(NUM_WIDTH'(shift_r));
    job.active = pos || neg;
    job.fin    = use_up ? in_data.upper_finite : in_data.lower_finite;
    job.first  = in_data.first_element;
    job.last   = in_data.last_element;
    job.start  = st;
    job.num    = num;
    job.den    = x;
  end
endmodule

[src/brtl_queue.sv]
// Two-entry job queue between front and back. Depends on brtl_pkg.
`timescale 1ns / 1ps
module brtl_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  brtl_pkg::job_t wr_job,
  output logic           rd_valid,
  input  logic           rd_ready,
  output brtl_pkg::job_t rd_job
);
  import brtl_pkg::*;

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_job   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem_r[wp_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= ~wp_r;
      if (rd_valid && rd_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'((wr_valid && wr_ready)) - 2'((rd_valid && rd_ready));
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !wr_ready) else $error("queue overflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("bad queue count");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !rd_valid |-> cnt_r == 2'd0) else $error("queue valid mismatch");
endmodule

[src/brtl_back.sv]
// Back part: restoring divider, saturation, limit update and result stage.
// Depends on brtl_pkg.
`timescale 1ns / 1ps
module brtl_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_ready,
  input  brtl_pkg::job_t     job,
  output logic               out_valid,
  input  logic               out_ready,
  output brtl_pkg::out_item_t out_data
);
  import brtl_pkg::*;

  back_state_t st_r, st_nxt;
  logic [DATA_WIDTH-1:0] limit_r, start_r, dmag_r, q_r, r_fin;
  logic                  upward_r, fin_r, last_r, neg_r, ovf_r, active_r;
  logic [DIVD_W-1:0]     divd_r;
  logic [DATA_WIDTH:0]   rem_r, rem_sh, rem_sub;
  logic [CNT_WIDTH-1:0]  cnt_r;
  logic [NUM_WIDTH-1:0]  nmag;
  logic [DATA_WIDTH-1:0] lim, cur_lim, cur_start;
  logic                  cur_up, tighter;
  logic                  load;

  assign load = st_r == ST_IDLE && job_valid;
  assign job_ready = st_r == ST_IDLE;
  assign out_valid = st_r == ST_OUT;
  assign out_data.step_limit  = 64'($signed(limit_r));
  assign out_data.limit_moved = limit_r != start_r;

  always_comb begin
    rem_sh  = {rem_r[DATA_WIDTH-1:0], divd_r[DIVD_W-1]};
    rem_sub = rem_sh - {1'b0, dmag_r};
    nmag = job.num[NUM_WIDTH-1] ? NUM_WIDTH'(-job.num) : NUM_WIDTH'(job.num);
    lim = neg_r ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : {1'b0, {(DATA_WIDTH-1){1'b1}}};
    r_fin = (ovf_r || q_r > lim) ? lim : q_r;
    r_fin = neg_r ? DATA_WIDTH'(-r_fin) : r_fin;
    tighter = upward_r ? $signed(limit_r) < $signed(r_fin)
                       : $signed(r_fin) < $signed(limit_r);
    cur_lim = job.first ? job.start : limit_r;
    cur_start = job.first ? job.start : start_r;
    cur_up = job.first ? job.start[DATA_WIDTH-1] : upward_r;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:  if (job_valid) st_nxt = job.active ? ST_DIV : (job.last ? ST_OUT : ST_IDLE);
      ST_DIV:   if (cnt_r == CNT_WIDTH'(0)) st_nxt = ST_APPLY;
      ST_APPLY: st_nxt = last_r ? ST_OUT : ST_IDLE;
      ST_OUT:   if (out_ready) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else        st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0; start_r <= '0; upward_r <= 1'b0;
    end else if (load) begin
      limit_r <= cur_lim; start_r <= cur_start; upward_r <= cur_up;
    end else if (st_r == ST_APPLY && tighter && fin_r) begin
      limit_r <= r_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fin_r  <= job.fin; last_r <= job.last; active_r <= job.active;
      neg_r  <= job.num[NUM_WIDTH-1] ^ job.den[DATA_WIDTH-1];
      dmag_r <= job.den[DATA_WIDTH-1] ? DATA_WIDTH'(-job.den) : job.den;
      divd_r <= {nmag, 32'd0};
      rem_r  <= '0; q_r <= '0; ovf_r <= 1'b0;
      cnt_r  <= CNT_WIDTH'(DIVD_W - 1);
    end else if (st_r == ST_DIV) begin
      divd_r <= {divd_r[DIVD_W-2:0], 1'b0};
      if (q_r[DATA_WIDTH-1]) ovf_r <= 1'b1;
      if (!rem_sub[DATA_WIDTH]) begin
        rem_r <= rem_sub; q_r <= {q_r[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;  q_r <= {q_r[DATA_WIDTH-2:0], 1'b0};
      end
      cnt_r <= cnt_r - CNT_WIDTH'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(limit_r)) else $error("result lost");
  a_div_active: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_DIV |-> active_r) else $error("divide on skipped item");
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != ST_IDLE |-> !job_ready) else $error("job taken while busy");
endmodule

[src/bounded_ratio_test_limit.sv]
// Top level of the bounded ratio test limit block.
// Depends on brtl_pkg, brtl_front, brtl_queue, brtl_back.
`timescale 1ns / 1ps
// Streams the elements of a sparse update vector and tightens a Q32.32 step
// limit against each element's bounds; one result item leaves per vector, on
// its last element. A front stage classifies each item (zero test, bound
// choice, numerator) and hands it to a two-entry queue; the back stage runs a
// radix-2 restoring divider, one quotient bit per cycle, then updates the
// limit. An item whose update passes the zero tolerance is divided; a
// skipped item is not. The back takes no new item until idle, so the
// divider sets the sustained rate. Configuration writes are taken in any cycle.
module bounded_ratio_test_limit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  brtl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output brtl_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [63:0]         cfg_data
);
  import brtl_pkg::*;

  job_t f_job, b_job;
  logic f_valid, f_ready, b_valid, b_ready;

  // Classify items as they arrive.
  brtl_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  // Decouple classification from the divider.
  brtl_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_job(f_job),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_job(b_job)
  );

  // Divide, saturate, tighten and deliver the result item.
  brtl_back u_back (
    .clk, .rst_n,
    .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
    .out_valid, .out_ready, .out_data
  );
endmodule
